@@ rtl/core/i2cms_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cms_pkg
// Types and constants shared by the I2C master transfer sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

  // request kinds
  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_WRITE  = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;
  localparam logic [1:0] REQ_STATUS = 2'd3;

  // bus status codes (status register bits 7..3)
  localparam logic [4:0] ST_START      = 5'd1;
  localparam logic [4:0] ST_REP_START  = 5'd2;
  localparam logic [4:0] ST_MT_SLA_ACK = 5'd3;
  localparam logic [4:0] ST_MT_SLA_NAK = 5'd4;
  localparam logic [4:0] ST_MT_DAT_ACK = 5'd5;
  localparam logic [4:0] ST_MR_SLA_ACK = 5'd8;
  localparam logic [4:0] ST_MR_DAT_ACK = 5'd10;
  localparam logic [4:0] ST_MR_DAT_NAK = 5'd11;

  // control words
  localparam logic [4:0] CW_NONE  = 5'h00;
  localparam logic [4:0] CW_GO    = 5'h1B;
  localparam logic [4:0] CW_NEXT  = 5'h13;
  localparam logic [4:0] CW_STOP  = 5'h16;
  localparam logic [4:0] CW_RSTOP = 5'h15;

  // saturation limit of the transfer position
  localparam logic [4:0] POS_MAX = 5'd31;

  // widest buffer address carried between modules
  localparam int MEM_AW_MAX = 8;

  typedef enum logic [1:0] {
    MODE_FREE = 2'd0,
    MODE_SEND = 2'd1,
    MODE_RECV = 2'd2
  } mode_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [3:0] buf_index;
    logic [7:0] byte_in;
    logic [7:0] device_addr;
    logic [4:0] length;
    logic [4:0] status_code;
  } req_item_t;

  typedef struct packed {
    logic [1:0] start_result;
    logic       ctrl_valid;
    logic [4:0] ctrl_word;
    logic       data_valid;
    logic [7:0] data_out;
    logic       use_mem;
    logic       rx_valid;
    logic [3:0] rx_index;
    logic [7:0] rx_byte;
    logic       done_res;
    logic [4:0] done_status;
  } rsp_item_t;

  typedef struct packed {
    logic                  we;
    logic [MEM_AW_MAX-1:0] waddr;
    logic [7:0]            wdata;
    logic                  re;
    logic [MEM_AW_MAX-1:0] raddr;
  } mem_req_t;

endpackage

@@ rtl/core/i2cms_if.sv @@
// ----------------------------------------------------------------------------
// i2cms_if
// Valid/ready channels for request and result items.
// ----------------------------------------------------------------------------
interface i2cms_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [3:0] buf_index;
  logic [7:0] byte_in;
  logic [7:0] device_addr;
  logic [4:0] length;
  logic [4:0] status_code;

  modport source (output valid, req_type, buf_index, byte_in, device_addr, length,
                  status_code, input ready);
  modport sink   (input valid, req_type, buf_index, byte_in, device_addr, length,
                  status_code, output ready);
endinterface

interface i2cms_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] start_result;
  logic       ctrl_valid;
  logic [4:0] ctrl_word;
  logic       data_valid;
  logic [7:0] data_out;
  logic       rx_valid;
  logic [3:0] rx_index;
  logic [7:0] rx_byte;
  logic       done_res;
  logic [4:0] done_status;

  modport source (output valid, start_result, ctrl_valid, ctrl_word, data_valid,
                  data_out, rx_valid, rx_index, rx_byte, done_res, done_status,
                  input ready);
  modport sink   (input valid, start_result, ctrl_valid, ctrl_word, data_valid,
                  data_out, rx_valid, rx_index, rx_byte, done_res, done_status,
                  output ready);
endinterface

@@ rtl/core/i2c_master_transfer_sequencer.sv @@
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer
// Sequences I2C master write and read transfers on a TWI-style bus engine.
// ----------------------------------------------------------------------------
// Each request item (load tx byte, start write, start read, bus status) gives
// exactly one result item: control word, optional data-register load, any
// received byte with its buffer index, and a completion event. The block
// takes one item per clock: the transfer state is decided and updated at the
// cycle an item is accepted, and the transmit buffer (a synchronous memory of
// BUF_DEPTH bytes) is read in that same cycle. The buffer's registered read
// lines up with the output register, so a result shows in the cycle after its
// item is accepted. A new item is taken whenever the output register is empty
// or its item is being taken in the same cycle. A load writes the buffer at
// its accept edge; any later status item reads it at a later edge, so no
// forwarding path is needed. Buffer entries never loaded read as unknown.
// ----------------------------------------------------------------------------
module i2c_master_transfer_sequencer
  import i2cms_pkg::*;
#(
  parameter int BUF_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  i2cms_req_if.sink   req,
  i2cms_rsp_if.source rsp
);

  req_item_t  item;
  rsp_item_t  rsp_comb;
  rsp_item_t  rsp_q;
  logic       rsp_valid;
  mem_req_t   mem_req;
  logic [7:0] mem_rdata;
  logic       accept;

  // take a new item when the output slot is free or drains this cycle
  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign item = '{
    req_type:    req.req_type,
    buf_index:   req.buf_index,
    byte_in:     req.byte_in,
    device_addr: req.device_addr,
    length:      req.length,
    status_code: req.status_code
  };

  i2cms_ctrl #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .item    (item),
    .rsp     (rsp_comb),
    .mem_req (mem_req)
  );

  // read data advances only with an accepted item, so it holds under stall
  i2cms_txbuf #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_txbuf (
    .clk     (clk),
    .mem_req (mem_req),
    .rdata   (mem_rdata)
  );

  // output register: hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_q <= rsp_comb;
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.start_result = rsp_q.start_result;
  assign rsp.ctrl_valid   = rsp_q.ctrl_valid;
  assign rsp.ctrl_word    = rsp_q.ctrl_word;
  assign rsp.data_valid   = rsp_q.data_valid;
  // buffer bytes come from the memory read; address bytes from the register
  assign rsp.data_out     = rsp_q.use_mem ? mem_rdata : rsp_q.data_out;
  assign rsp.rx_valid     = rsp_q.rx_valid;
  assign rsp.rx_index     = rsp_q.rx_index;
  assign rsp.rx_byte      = rsp_q.rx_byte;
  assign rsp.done_res     = rsp_q.done_res;
  assign rsp.done_status  = rsp_q.done_status;

endmodule

@@ rtl/core/i2cms_txbuf.sv @@
// ----------------------------------------------------------------------------
// i2cms_txbuf
// Transmit byte buffer: one write port, one registered read port.
// ----------------------------------------------------------------------------
module i2cms_txbuf
  import i2cms_pkg::*;
#(
  parameter int BUF_DEPTH = 16
) (
  input  logic       clk,
  input  mem_req_t   mem_req,
  output logic [7:0] rdata
);

  localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

  logic [7:0] mem [BUF_DEPTH];

  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.waddr[AW-1:0]] <= mem_req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_req.re) begin
      rdata <= mem[mem_req.raddr[AW-1:0]];
    end
  end

endmodule

@@ rtl/core/i2cms_ctrl.sv @@
// ----------------------------------------------------------------------------
// i2cms_ctrl
// Transfer state and per-item decision; issues buffer reads and writes.
// ----------------------------------------------------------------------------
module i2cms_ctrl
  import i2cms_pkg::*;
#(
  parameter int BUF_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      accept,
  input  req_item_t item,
  output rsp_item_t rsp,
  output mem_req_t  mem_req
);

  mode_t      mode, mode_next;
  logic [7:0] target_addr, target_addr_next;
  logic [4:0] position, position_next;
  logic [4:0] xfer_length, xfer_length_next;

  logic       fetch;
  logic       finish;
  logic       pos_in_buf;
  logic [4:0] pos_inc;
  logic [8:0] len_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_FREE;
      target_addr <= '0;
      position    <= '0;
      xfer_length <= '0;
    end else if (accept) begin
      mode        <= mode_next;
      target_addr <= target_addr_next;
      position    <= position_next;
      xfer_length <= xfer_length_next;
    end
  end

  assign pos_in_buf = {4'd0, position} < 9'(BUF_DEPTH);
  assign pos_inc    = (position < POS_MAX) ? position + 5'd1 : position;
  assign len_sat    = ({4'd0, item.length} > 9'(BUF_DEPTH)) ? 9'(BUF_DEPTH)
                                                             : {4'd0, item.length};

  always_comb begin
    mode_next        = mode;
    target_addr_next = target_addr;
    position_next    = position;
    xfer_length_next = xfer_length;
    rsp              = '0;
    fetch            = 1'b0;
    finish           = 1'b0;

    mem_req.we    = accept && (item.req_type == REQ_LOAD)
                    && ({5'd0, item.buf_index} < 9'(BUF_DEPTH));
    mem_req.waddr = {4'd0, item.buf_index};
    mem_req.wdata = item.byte_in;
    mem_req.re    = accept;
    mem_req.raddr = {3'd0, position};

    unique case (item.req_type)
      REQ_LOAD: begin
      end
      REQ_WRITE, REQ_READ: begin
        if (mode == MODE_SEND || mode == MODE_RECV) begin
          rsp.start_result = mode;
        end else begin
          target_addr_next = item.device_addr;
          position_next    = '0;
          xfer_length_next = len_sat[4:0];
          mode_next        = (item.req_type == REQ_WRITE) ? MODE_SEND : MODE_RECV;
          rsp.ctrl_valid   = 1'b1;
          rsp.ctrl_word    = CW_GO;
        end
      end
      default: begin
        rsp.ctrl_valid = 1'b1;
        unique case (mode)
          MODE_SEND: begin
            unique case (item.status_code)
              ST_START: begin
                rsp.data_valid = 1'b1;
                rsp.data_out   = target_addr;
                rsp.ctrl_word  = CW_NEXT;
              end
              ST_MT_SLA_ACK: begin
                fetch         = 1'b1;
                rsp.ctrl_word = CW_NEXT;
              end
              ST_MT_DAT_ACK: begin
                if (position < xfer_length) begin
                  fetch         = 1'b1;
                  rsp.ctrl_word = CW_NEXT;
                end else begin
                  rsp.ctrl_word = CW_STOP;
                  finish        = 1'b1;
                end
              end
              ST_MT_SLA_NAK: begin
                rsp.ctrl_word = CW_STOP;
                finish        = 1'b1;
              end
              default: begin
                rsp.ctrl_word = CW_NONE;
                finish        = 1'b1;
              end
            endcase
          end
          MODE_RECV: begin
            unique case (item.status_code)
              ST_START, ST_MT_SLA_NAK: begin
                rsp.data_valid = 1'b1;
                rsp.data_out   = target_addr;
                rsp.ctrl_word  = (item.status_code == ST_START) ? CW_NEXT : CW_GO;
              end
              ST_REP_START, ST_MR_SLA_ACK: begin
                rsp.ctrl_word = CW_NEXT;
              end
              ST_MR_DAT_ACK, ST_MR_DAT_NAK: begin
                rsp.rx_valid  = 1'b1;
                rsp.rx_index  = position[3:0];
                rsp.rx_byte   = item.byte_in;
                position_next = pos_inc;
                if (pos_inc < xfer_length) begin
                  if (item.status_code == ST_MR_DAT_ACK) begin
                    rsp.ctrl_word = CW_NEXT;
                  end else begin
                    rsp.data_valid = 1'b1;
                    rsp.data_out   = target_addr;
                    rsp.ctrl_word  = CW_GO;
                  end
                end else begin
                  rsp.ctrl_word = (item.status_code == ST_MR_DAT_ACK) ? CW_RSTOP : CW_STOP;
                  finish        = 1'b1;
                end
              end
              default: begin
                rsp.ctrl_word = CW_NONE;
                finish        = 1'b1;
              end
            endcase
          end
          default: begin
            rsp.ctrl_word = CW_NONE;
            mode_next     = MODE_FREE;
          end
        endcase
      end
    endcase

    // send the buffer byte at the current position; past the buffer send zero
    if (fetch) begin
      rsp.data_valid = 1'b1;
      rsp.use_mem    = pos_in_buf;
      position_next  = pos_inc;
    end

    if (finish) begin
      mode_next       = MODE_FREE;
      rsp.done_res    = 1'b1;
      rsp.done_status = item.status_code;
    end
  end

endmodule
